[hdl/ptfm_pkg.sv]
// Shared types and constants of the page table frame mapper.
// Used by ptfm_ctrl, ptfm_dp and page_table_frame_mapper; depends on nothing.
package ptfm_pkg;

    localparam int PAGES       = 128;
    localparam int PAGE_W      = 7;
    localparam int END_W       = 8;
    localparam int IDX_W       = PAGE_W + 1;
    localparam int TBL_ENTRIES = 2 * PAGES;
    localparam int FRAMES      = 1024;
    localparam int FRAME_W     = 10;
    localparam int FIFO_PTR_W  = 10;
    localparam int COUNT_W     = 11;
    localparam int PROT_W      = 3;
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 2;
    localparam int FLUSH_W     = 2;

    localparam logic [END_W-1:0]   END_MAX    = END_W'(PAGES);
    localparam logic [COUNT_W-1:0] FIFO_LIMIT = COUNT_W'(FRAMES);

    localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_MAP   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_UNMAP = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PROT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FRAME = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

    localparam logic [FLUSH_W-1:0] FLUSH_NONE   = 2'd0;
    localparam logic [FLUSH_W-1:0] FLUSH_KERNEL = 2'd1;
    localparam logic [FLUSH_W-1:0] FLUSH_USER   = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic               table_sel;
        logic [PAGE_W-1:0]  start_page;
        logic [END_W-1:0]   end_page;
        logic [PROT_W-1:0]  protection;
        logic [FRAME_W-1:0] frame_number;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                entry_valid;
        logic [PROT_W-1:0]   entry_protection;
        logic [FRAME_W-1:0]  entry_frame;
        logic [FLUSH_W-1:0]  flush_request;
        logic [COUNT_W-1:0]  free_count;
    } t_out_item;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic push_in;
        logic status_full;
        logic set_flush;
        logic ptr_inc;
        logic fifo_rd;
        logic map_wr;
        logic rollback;
        logic frame_rd;
        logic rel_push;
        logic prot_wr;
        logic entry_rd;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             at_end;
        logic             cur_valid;
        logic             fifo_empty;
        logic             fifo_full;
    } t_dp_stat;

endpackage

[hdl/ptfm_dp.sv]
// Datapath of the page table frame mapper: command latch, walk pointer,
// table stores, valid bits and the free frame FIFO. Depends on ptfm_pkg.
module ptfm_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ptfm_pkg::t_in_item   i_item,
    input  ptfm_pkg::t_dp_cmd    i_cmd,
    output ptfm_pkg::t_dp_stat   o_stat,
    output ptfm_pkg::t_out_item  o_result
);

    // Latched command item
    logic [ptfm_pkg::CMD_W-1:0]    r_cmd;
    logic                          r_sel;
    logic [ptfm_pkg::PAGE_W-1:0]   r_start;
    logic [ptfm_pkg::PROT_W-1:0]   r_prot;
    logic [ptfm_pkg::FRAME_W-1:0]  r_frame_in;

    // Walk and result control
    logic [ptfm_pkg::END_W-1:0]    r_ptr;
    logic [ptfm_pkg::END_W-1:0]    r_limit;
    logic [ptfm_pkg::STATUS_W-1:0] r_status;
    logic [ptfm_pkg::FLUSH_W-1:0]  r_flush;
    logic                          r_rd_en;
    logic                          r_rd_v;
    logic                          r_rd_wr;

    // Free frame FIFO control
    logic [ptfm_pkg::FIFO_PTR_W-1:0] r_head;
    logic [ptfm_pkg::FIFO_PTR_W-1:0] r_tail;
    logic [ptfm_pkg::COUNT_W-1:0]    r_used;

    // Per-entry flags; an entry that was never written reads as zero
    logic [ptfm_pkg::TBL_ENTRIES-1:0] r_valid;
    logic [ptfm_pkg::TBL_ENTRIES-1:0] r_written;

    // Stores and their read registers
    logic [ptfm_pkg::PROT_W-1:0]  r_prot_mem  [ptfm_pkg::TBL_ENTRIES];
    logic [ptfm_pkg::FRAME_W-1:0] r_frame_mem [ptfm_pkg::TBL_ENTRIES];
    logic [ptfm_pkg::FRAME_W-1:0] r_fifo_mem  [ptfm_pkg::FRAMES];
    logic [ptfm_pkg::PROT_W-1:0]  r_prot_q;
    logic [ptfm_pkg::FRAME_W-1:0] r_frame_q;
    logic [ptfm_pkg::FRAME_W-1:0] r_fifo_q;

    logic [ptfm_pkg::IDX_W-1:0]   idx;
    logic [ptfm_pkg::END_W-1:0]   n_limit;
    logic [ptfm_pkg::FRAME_W-1:0] fifo_wdata;
    logic                         fifo_we;

    assign idx        = {r_sel, r_ptr[ptfm_pkg::PAGE_W-1:0]};
    assign n_limit    = (i_item.end_page > ptfm_pkg::END_MAX) ? ptfm_pkg::END_MAX
                                                             : i_item.end_page;
    assign fifo_we    = i_cmd.push_in | i_cmd.rel_push;
    assign fifo_wdata = i_cmd.push_in ? r_frame_in : r_frame_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd      <= i_item.cmd;
            r_sel      <= i_item.table_sel;
            r_start    <= i_item.start_page;
            r_prot     <= i_item.protection;
            r_frame_in <= i_item.frame_number;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr      <= '0;
            r_limit    <= '0;
            r_status   <= ptfm_pkg::STATUS_OK;
            r_flush    <= ptfm_pkg::FLUSH_NONE;
            r_rd_en    <= 1'b0;
            r_head     <= '0;
            r_tail     <= '0;
            r_used     <= '0;
            r_valid    <= '0;
            r_written  <= '0;
        end else begin
            if (i_cmd.load) begin
                r_ptr    <= {1'b0, i_item.start_page};
                r_limit  <= n_limit;
                r_status <= ptfm_pkg::STATUS_OK;
                r_flush  <= ptfm_pkg::FLUSH_NONE;
                r_rd_en  <= 1'b0;
            end else if (i_cmd.rollback) begin
                // release from the range start up to the failing page
                r_limit  <= r_ptr;
                r_ptr    <= {1'b0, r_start};
                r_status <= ptfm_pkg::STATUS_NO_FRAME;
            end else if (i_cmd.ptr_inc) begin
                r_ptr <= r_ptr + 1'b1;
            end
            if (i_cmd.status_full) begin
                r_status <= ptfm_pkg::STATUS_FULL;
            end
            if (i_cmd.set_flush) begin
                r_flush <= r_sel ? ptfm_pkg::FLUSH_USER : ptfm_pkg::FLUSH_KERNEL;
            end
            if (i_cmd.entry_rd) begin
                r_rd_en <= 1'b1;
            end
            if (fifo_we) begin
                r_tail <= r_tail + 1'b1;
                r_used <= r_used + 1'b1;
            end
            if (i_cmd.map_wr) begin
                r_head         <= r_head + 1'b1;
                r_used         <= r_used - 1'b1;
                r_valid[idx]   <= 1'b1;
                r_written[idx] <= 1'b1;
            end
            if (i_cmd.rel_push) begin
                r_valid[idx] <= 1'b0;
            end
            if (i_cmd.prot_wr) begin
                r_written[idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.entry_rd) begin
            r_rd_v  <= r_valid[idx];
            r_rd_wr <= r_written[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.map_wr || i_cmd.prot_wr) begin
            r_prot_mem[idx] <= r_prot;
        end
        if (i_cmd.entry_rd) begin
            r_prot_q <= r_prot_mem[idx];
        end
    end

    // A protection write to a fresh entry zeroes its frame alongside.
    always_ff @(posedge i_clk) begin
        if (i_cmd.map_wr) begin
            r_frame_mem[idx] <= r_fifo_q;
        end else if (i_cmd.prot_wr && !r_written[idx]) begin
            r_frame_mem[idx] <= '0;
        end
        if (i_cmd.frame_rd || i_cmd.entry_rd) begin
            r_frame_q <= r_frame_mem[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fifo_we) begin
            r_fifo_mem[r_tail] <= fifo_wdata;
        end
        if (i_cmd.fifo_rd) begin
            r_fifo_q <= r_fifo_mem[r_head];
        end
    end

    always_comb begin
        o_stat.cmd        = r_cmd;
        o_stat.at_end     = (r_ptr >= r_limit);
        o_stat.cur_valid  = r_valid[idx];
        o_stat.fifo_empty = (r_used == '0);
        o_stat.fifo_full  = (r_used >= ptfm_pkg::FIFO_LIMIT);
    end

    always_comb begin
        o_result.status           = r_status;
        o_result.entry_valid      = r_rd_en & r_rd_v;
        o_result.entry_protection = (r_rd_en && r_rd_wr) ? r_prot_q : '0;
        o_result.entry_frame      = (r_rd_en && r_rd_wr) ? r_frame_q : '0;
        o_result.flush_request    = r_flush;
        o_result.free_count       = r_used;
    end

endmodule

[hdl/ptfm_ctrl.sv]
// Controller of the page table frame mapper: sequences each command as
// datapath steps. Depends on ptfm_pkg.
module ptfm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_free,
    input  ptfm_pkg::t_dp_stat  i_stat,
    output logic                o_in_ready,
    output logic                o_done,
    output ptfm_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_DECODE   = 10'b0000000010,
        S_MAP_CHK  = 10'b0000000100,
        S_MAP_WR   = 10'b0000001000,
        S_REL_CHK  = 10'b0000010000,
        S_REL_PUSH = 10'b0000100000,
        S_PROT     = 10'b0001000000,
        S_READ     = 10'b0010000000,
        S_DONE     = 10'b0100000000,
        S_PUSH     = 10'b1000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.cmd)
                    ptfm_pkg::CMD_PUSH: begin
                        n_state = S_PUSH;
                    end
                    ptfm_pkg::CMD_MAP: begin
                        o_cmd.set_flush = 1'b1;
                        n_state         = S_MAP_CHK;
                    end
                    ptfm_pkg::CMD_UNMAP: begin
                        o_cmd.set_flush = !i_stat.at_end;
                        n_state         = S_REL_CHK;
                    end
                    ptfm_pkg::CMD_PROT: begin
                        o_cmd.set_flush = 1'b1;
                        n_state         = S_PROT;
                    end
                    ptfm_pkg::CMD_READ: begin
                        o_cmd.entry_rd = 1'b1;
                        n_state        = S_READ;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_PUSH: begin
                if (i_stat.fifo_full) begin
                    o_cmd.status_full = 1'b1;
                end else begin
                    o_cmd.push_in = 1'b1;
                end
                n_state = S_DONE;
            end
            S_MAP_CHK: begin
                if (i_stat.at_end) begin
                    n_state = S_DONE;
                end else if (i_stat.cur_valid) begin
                    o_cmd.ptr_inc = 1'b1;
                end else if (i_stat.fifo_empty) begin
                    o_cmd.rollback = 1'b1;
                    n_state        = S_REL_CHK;
                end else begin
                    o_cmd.fifo_rd = 1'b1;
                    n_state       = S_MAP_WR;
                end
            end
            S_MAP_WR: begin
                o_cmd.map_wr  = 1'b1;
                o_cmd.ptr_inc = 1'b1;
                n_state       = S_MAP_CHK;
            end
            S_REL_CHK: begin
                if (i_stat.at_end) begin
                    n_state = S_DONE;
                end else if (!i_stat.cur_valid) begin
                    o_cmd.ptr_inc = 1'b1;
                end else if (i_stat.fifo_full) begin
                    // map rollback keeps its no-frame status
                    o_cmd.status_full = (i_stat.cmd == ptfm_pkg::CMD_UNMAP);
                    n_state           = S_DONE;
                end else begin
                    o_cmd.frame_rd = 1'b1;
                    n_state        = S_REL_PUSH;
                end
            end
            S_REL_PUSH: begin
                o_cmd.rel_push = 1'b1;
                o_cmd.ptr_inc  = 1'b1;
                n_state        = S_REL_CHK;
            end
            S_PROT: begin
                if (i_stat.at_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.prot_wr = 1'b1;
                    o_cmd.ptr_inc = 1'b1;
                end
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[hdl/page_table_frame_mapper.sv]
// Top level of the page table frame mapper: controller, datapath and the
// result register. Depends on ptfm_pkg, ptfm_ctrl and ptfm_dp.
//
//  channel   direction  handshake                  beat
//  in        sink       i_in_valid / o_in_ready    t_in_item: one command
//  out       source     o_out_valid / i_out_ready  t_out_item: one result
//
// One command at a time; a command is taken only while the controller idles.
// Map and unmap walk the range page by page: a page that touches the FIFO
// takes a check and a write step (the FIFO and frame stores have registered
// reads), a skipped page only the check step; a map that runs dry adds a
// release walk over the pages already covered. Set-protection writes one
// entry a cycle. Reset (i_rst_n low, synchronous) clears all valid bits and
// FIFO pointers at once; no clearing pass. A stalled result waits in the
// output register while the next command is taken and worked on.
module page_table_frame_mapper (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ptfm_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ptfm_pkg::t_out_item  o_out_item
);

    ptfm_pkg::t_dp_cmd   dp_cmd;
    ptfm_pkg::t_dp_stat  dp_stat;
    ptfm_pkg::t_out_item dp_result;

    logic                r_out_valid;
    ptfm_pkg::t_out_item r_out_item;
    logic                out_free;
    logic                done;

    // The result register is free when empty or when its beat leaves now.
    assign out_free = !r_out_valid || i_out_ready;

    ptfm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .i_stat     (dp_stat),
        .o_in_ready (o_in_ready),
        .o_done     (done),
        .o_cmd      (dp_cmd)
    );

    ptfm_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_in_item),
        .i_cmd    (dp_cmd),
        .o_stat   (dp_stat),
        .o_result (dp_result)
    );

    // Load the finished result; hold it until the sink takes the beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_item <= dp_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
